>>> rtl/assert_macros.svh
// Assertion macros shared by the deframer RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cond holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: cond does not hold");

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication does not hold");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication does not hold");

`endif

>>> rtl/tvpd_pkg.sv
// Shared types and constants for the thermal video packet deframer.
// No dependencies; imported by every deframer module.
package tvpd_pkg;

    localparam int BYTE_W      = 8;
    localparam int PIX_W       = 16;
    localparam int ROW_W       = 8;
    localparam int ROW_IDX_W   = 6;
    localparam int COL_IDX_W   = 7;

    localparam int ROWS_DEFAULT = 60;
    localparam int COLS_DEFAULT = 80;

    localparam int HEADER_BYTES = 4;

    // Header byte positions with a meaning of their own
    localparam int HDR_FLAGS_POS = 0;
    localparam int HDR_ROW_POS   = 1;

    localparam logic [3:0] DISCARD_NIBBLE = 4'hF;

    localparam logic [PIX_W-1:0] MIN_INIT = {PIX_W{1'b1}};
    localparam logic [PIX_W-1:0] MAX_INIT = '0;

    typedef struct packed {
        logic update;   // a pixel is taken into the extremes
        logic clear;    // frame ends with this pixel
    } tvpd_ext_ctrl_t;

endpackage

>>> rtl/tvpd_extremes.sv
// Running minimum and maximum over the pixels of one frame.
// Depends on tvpd_pkg.
`include "assert_macros.svh"

module tvpd_extremes
    import tvpd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  tvpd_ext_ctrl_t       ctrl,
    input  logic [PIX_W-1:0]     pixel,
    output logic [PIX_W-1:0]     min_with_pixel,
    output logic [PIX_W-1:0]     max_with_pixel
);

    logic [PIX_W-1:0] min_reg;
    logic [PIX_W-1:0] max_reg;
    logic [PIX_W-1:0] min_next;
    logic [PIX_W-1:0] max_next;

    // Extremes as they stand once this pixel is counted
    assign min_with_pixel = (pixel < min_reg) ? pixel : min_reg;
    assign max_with_pixel = (pixel > max_reg) ? pixel : max_reg;

    always_comb
    begin
        min_next = min_reg;
        max_next = max_reg;
        if (ctrl.update)
        begin
            if (ctrl.clear)
            begin
                min_next = MIN_INIT;
                max_next = MAX_INIT;
            end
            else
            begin
                min_next = min_with_pixel;
                max_next = max_with_pixel;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= MIN_INIT;
            max_reg <= MAX_INIT;
        end
        else
        begin
            min_reg <= min_next;
            max_reg <= max_next;
        end
    end

    // After a cleared update the extremes are back at their initial values
    `ASSERT_NEXT(a_clear_restores, clk, rst_n, ctrl.update && ctrl.clear, min_reg == MIN_INIT && max_reg == MAX_INIT)
    // Once a pixel has been counted without a clear, min cannot exceed max
    `ASSERT_NEXT(a_update_orders, clk, rst_n, ctrl.update && !ctrl.clear, min_reg <= max_reg)

endmodule

>>> rtl/thermal_video_packet_deframer_core.sv
// Top level of the thermal video packet deframer: byte stream in, pixels out.
// Depends on tvpd_pkg and tvpd_extremes.
//
//  channel  | valid         | ready         | payload
//  ---------+---------------+---------------+-------------------------------------------
//  byte in  | byte_valid    | byte_ready    | rx_byte, packet_start
//  pixel out| result_valid  | result_ready  | pixel_valid, row_index, column_index,
//           |               |               | pixel_value, frame_done, frame_min, frame_max
//
// One byte is taken per cycle unless stalled; a pixel result is loaded into the output
// register as its low byte is accepted. Header bytes and high bytes give no result.
// Reset clears byte count, discard flag, row, high byte; sets the min/max pair to init.
// byte_ready drops only while the output register holds a result that is stalled.
`include "assert_macros.svh"

module thermal_video_packet_deframer_core
    import tvpd_pkg::*;
#(
    parameter int ROWS = ROWS_DEFAULT,
    parameter int COLS = COLS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  byte_valid,
    output logic                  byte_ready,
    input  logic [BYTE_W-1:0]     rx_byte,
    input  logic                  packet_start,

    output logic                  result_valid,
    input  logic                  result_ready,
    output logic                  pixel_valid,
    output logic [ROW_IDX_W-1:0]  row_index,
    output logic [COL_IDX_W-1:0]  column_index,
    output logic [PIX_W-1:0]      pixel_value,
    output logic                  frame_done,
    output logic [PIX_W-1:0]      frame_min,
    output logic [PIX_W-1:0]      frame_max
);

    localparam int PACKET_BYTES = HEADER_BYTES + 2 * COLS;
    localparam int POS_W        = $clog2(PACKET_BYTES);

    localparam logic [POS_W-1:0] POS_FLAGS = POS_W'(HDR_FLAGS_POS);
    localparam logic [POS_W-1:0] POS_ROW   = POS_W'(HDR_ROW_POS);
    localparam logic [POS_W-1:0] POS_PIX0  = POS_W'(HEADER_BYTES);
    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(PACKET_BYTES - 1);
    localparam logic [POS_W-1:0] POS_STEP  = POS_W'(1);
    localparam logic [ROW_W-1:0] ROW_LIMIT = ROW_W'(ROWS);
    localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(ROWS - 1);
    localparam logic [COL_IDX_W-1:0] COL_LAST = COL_IDX_W'(COLS - 1);

    logic [POS_W-1:0]      pos_reg;
    logic [POS_W-1:0]      pos_next;
    logic                  discard_reg;
    logic                  discard_next;
    logic [ROW_W-1:0]      row_reg;
    logic [ROW_W-1:0]      row_next;
    logic [BYTE_W-1:0]     high_reg;
    logic [BYTE_W-1:0]     high_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [ROW_IDX_W-1:0]  out_row_reg;
    logic [COL_IDX_W-1:0]  out_col_reg;
    logic [PIX_W-1:0]      out_pix_reg;
    logic                  out_done_reg;
    logic [PIX_W-1:0]      out_min_reg;
    logic [PIX_W-1:0]      out_max_reg;

    logic                  accept;
    logic [POS_W-1:0]      pos;
    logic [POS_W-1:0]      off;
    logic [COL_IDX_W-1:0]  col;
    logic [PIX_W-1:0]      pix;
    logic                  emit;
    logic                  done;
    logic [PIX_W-1:0]      min_with_pixel;
    logic [PIX_W-1:0]      max_with_pixel;
    tvpd_ext_ctrl_t        ext_ctrl;

    assign byte_ready = !out_valid_reg || result_ready;
    assign accept     = byte_valid && byte_ready;

    // Start flag forces the count back to the first header byte
    assign pos  = packet_start ? POS_FLAGS : pos_reg;
    assign off  = pos - POS_PIX0;
    assign col  = COL_IDX_W'(off >> 1);
    assign pix  = {high_reg, rx_byte};
    assign emit = accept && (pos >= POS_PIX0) && off[0] && !discard_reg;
    assign done = (row_reg == ROW_LAST) && (col == COL_LAST);

    always_comb
    begin
        discard_next = discard_reg;
        row_next     = row_reg;
        high_next    = high_reg;
        pos_next     = pos_reg;
        if (accept)
        begin
            if (pos == POS_FLAGS)
            begin
                discard_next = (rx_byte[3:0] == DISCARD_NIBBLE);
            end
            else if (pos == POS_ROW)
            begin
                row_next = rx_byte;
                if (rx_byte >= ROW_LIMIT)
                begin
                    discard_next = 1'b1;
                end
            end
            else if (pos >= POS_PIX0 && !off[0])
            begin
                high_next = rx_byte;
            end
            // Wrap after the last byte of the packet
            pos_next = (pos == POS_LAST) ? POS_FLAGS : pos + POS_STEP;
        end
    end

    assign ext_ctrl.update = emit;
    assign ext_ctrl.clear  = done;

    tvpd_extremes u_extremes
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ext_ctrl),
        .pixel          (pix),
        .min_with_pixel (min_with_pixel),
        .max_with_pixel (max_with_pixel)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            discard_reg   <= 1'b0;
            row_reg       <= '0;
            high_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            discard_reg   <= discard_next;
            row_reg       <= row_next;
            high_reg      <= high_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload: load on emit, hold otherwise
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_row_reg  <= row_reg[ROW_IDX_W-1:0];
            out_col_reg  <= col;
            out_pix_reg  <= pix;
            out_done_reg <= done;
            out_min_reg  <= done ? min_with_pixel : '0;
            out_max_reg  <= done ? max_with_pixel : '0;
        end
    end

    assign result_valid = out_valid_reg;
    assign pixel_valid  = 1'b1;
    assign row_index    = out_row_reg;
    assign column_index = out_col_reg;
    assign pixel_value  = out_pix_reg;
    assign frame_done   = out_done_reg;
    assign frame_min    = out_min_reg;
    assign frame_max    = out_max_reg;

    `ASSERT_ALWAYS(a_pos_in_packet, clk, rst_n, pos_reg <= POS_LAST)
    `ASSERT_IMPLY(a_done_last_col, clk, rst_n, result_valid && frame_done,
                  column_index == COL_LAST)
    `ASSERT_IMPLY(a_done_orders, clk, rst_n, result_valid && frame_done,
                  frame_min <= pixel_value && pixel_value <= frame_max)
    `ASSERT_IMPLY(a_no_extremes_midframe, clk, rst_n, result_valid && !frame_done,
                  frame_min == '0 && frame_max == '0)

endmodule
